@@ rtl/pfp_pkg.sv @@
// Shared types, constants and helpers for the plane-from-three-points pipeline.
`default_nettype none
package pfp_pkg;

  // Default parameter values
  localparam int COORD_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF  = 15;

  // Fixed datapath widths
  localparam int SQ_W       = 64;   // normalized sum of squares
  localparam int ROOT_W     = 32;   // integer square root of SQ_W bits
  localparam int ROOT_STEPS = 32;   // one result bit per root cell
  localparam int K_W        = 5;    // normalize shift count, 0..31
  localparam int LANES      = 4;    // three normal lanes and the offset lane
  localparam int OFF_LANE   = 3;
  localparam int NORM_W     = 16;
  localparam int OFF_W      = 28;

  // Output limits
  localparam longint NORM_MAX     = 64'd32767;
  localparam longint NORM_MIN_MAG = 64'd32768;
  localparam longint OFF_MAX      = 64'd134217727;
  localparam longint OFF_MIN_MAG  = 64'd134217728;

  // Control word that travels with every request down the chain
  typedef struct packed {
    logic       vld;
    logic       zero;     // cross product is zero
    logic [2:0] neg_c;    // sign of each cross product component
    logic       dot_pos;  // c . first is strictly positive
  } pfp_ctl_t;

  // Apply sign to a magnitude, clamping against the positive limit or the
  // magnitude of the negative limit; two's complement result.
  function automatic logic [63:0] sat_apply(input logic [63:0] mag, input logic neg,
                                            input logic [63:0] hi, input logic [63:0] lom);
    logic [63:0] m;
    if (neg) begin
      m = (mag > lom) ? lom : mag;
      return -m;
    end else begin
      return (mag > hi) ? hi : mag;
    end
  endfunction

endpackage
`default_nettype wire

@@ rtl/pfp_front.sv @@
// Front pipeline: edge vectors, cross product, squares, dot product, sums.
`default_nettype none
module pfp_front import pfp_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  req_i,
  input  wire logic [2:0][COORD_BITS-1:0]            pa_i,
  input  wire logic [2:0][COORD_BITS-1:0]            pb_i,
  input  wire logic [2:0][COORD_BITS-1:0]            pc_i,
  output pfp_ctl_t                                   ctl_o,
  output logic [SQ_W-1:0]                            sq_o,
  output logic [2:0][2*COORD_BITS:0]                 magc_o,
  output logic [3*COORD_BITS+1:0]                    magd_o
);

  localparam int DW  = COORD_BITS + 1;       // edge vector
  localparam int PW  = 2 * COORD_BITS + 2;   // product / cross component
  localparam int CMW = 2 * COORD_BITS + 1;   // cross magnitude
  localparam int SQW = 4 * COORD_BITS + 2;   // squared magnitude
  localparam int CPW = 3 * COORD_BITS + 1;   // c_i * p_i
  localparam int DTW = 3 * COORD_BITS + 3;   // dot product
  localparam int MDW = DTW - 1;

  logic [4:0] vld_q;

  logic signed [DW-1:0]  s1_u_q [3];
  logic signed [DW-1:0]  s1_v_q [3];
  logic [COORD_BITS-1:0] s1_p_q [3];

  logic signed [PW-1:0]  s2_m_q [6];
  logic [COORD_BITS-1:0] s2_p_q [3];

  logic signed [PW-1:0]  s3_c_q [3];
  logic [CMW-1:0]        s3_mag_q [3];
  logic [COORD_BITS-1:0] s3_p_q [3];

  logic [SQW-1:0]        s4_sq_q [3];
  logic signed [CPW-1:0] s4_cp_q [3];
  logic [CMW-1:0]        s4_mag_q [3];
  logic                  s4_zero_q;
  logic [2:0]            s4_neg_q;

  logic                  s5_zero_q;
  logic [2:0]            s5_neg_q;
  logic                  s5_dpos_q;
  logic [SQ_W-1:0]       s5_sq_q;
  logic [2:0][CMW-1:0]   s5_mag_q;
  logic [MDW-1:0]        s5_magd_q;

  logic signed [DTW-1:0] dot_d;

  // Valid shift
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[3:0], req_i};
    end
  end

  assign dot_d = DTW'(s4_cp_q[0]) + DTW'(s4_cp_q[1]) + DTW'(s4_cp_q[2]);

  // Datapath stages
  always_ff @(posedge clk_i) begin
    // stage 1: edge vectors
    for (int i = 0; i < 3; i++) begin
      s1_u_q[i] <= DW'(signed'(pb_i[i])) - DW'(signed'(pa_i[i]));
      s1_v_q[i] <= DW'(signed'(pc_i[i])) - DW'(signed'(pa_i[i]));
      s1_p_q[i] <= pa_i[i];
    end
    // stage 2: cross product partial products
    s2_m_q[0] <= PW'(s1_u_q[1]) * PW'(s1_v_q[2]);
    s2_m_q[1] <= PW'(s1_u_q[2]) * PW'(s1_v_q[1]);
    s2_m_q[2] <= PW'(s1_u_q[2]) * PW'(s1_v_q[0]);
    s2_m_q[3] <= PW'(s1_u_q[0]) * PW'(s1_v_q[2]);
    s2_m_q[4] <= PW'(s1_u_q[0]) * PW'(s1_v_q[1]);
    s2_m_q[5] <= PW'(s1_u_q[1]) * PW'(s1_v_q[0]);
    for (int i = 0; i < 3; i++) begin
      s2_p_q[i] <= s1_p_q[i];
    end
    // stage 3: cross product and magnitudes
    for (int i = 0; i < 3; i++) begin
      s3_c_q[i]   <= s2_m_q[2*i] - s2_m_q[2*i+1];
      s3_mag_q[i] <= (s2_m_q[2*i] < s2_m_q[2*i+1]) ?
                     CMW'(s2_m_q[2*i+1] - s2_m_q[2*i]) : CMW'(s2_m_q[2*i] - s2_m_q[2*i+1]);
      s3_p_q[i]   <= s2_p_q[i];
    end
    // stage 4: squares and dot terms
    for (int i = 0; i < 3; i++) begin
      s4_sq_q[i]  <= SQW'(s3_mag_q[i]) * SQW'(s3_mag_q[i]);
      s4_cp_q[i]  <= CPW'(s3_c_q[i]) * CPW'(signed'(s3_p_q[i]));
      s4_mag_q[i] <= s3_mag_q[i];
      s4_neg_q[i] <= s3_c_q[i][PW-1];
    end
    s4_zero_q <= (s3_mag_q[0] == '0) && (s3_mag_q[1] == '0) && (s3_mag_q[2] == '0);
    // stage 5: sums
    s5_sq_q   <= SQ_W'(s4_sq_q[0]) + SQ_W'(s4_sq_q[1]) + SQ_W'(s4_sq_q[2]);
    s5_magd_q <= dot_d[DTW-1] ? MDW'(-dot_d) : MDW'(dot_d);
    s5_dpos_q <= !dot_d[DTW-1] && (dot_d != '0);
    s5_zero_q <= s4_zero_q;
    s5_neg_q  <= s4_neg_q;
    for (int i = 0; i < 3; i++) begin
      s5_mag_q[i] <= s4_mag_q[i];
    end
  end

  assign ctl_o.vld     = vld_q[4];
  assign ctl_o.zero    = s5_zero_q;
  assign ctl_o.neg_c   = s5_neg_q;
  assign ctl_o.dot_pos = s5_dpos_q;
  assign sq_o          = s5_sq_q;
  assign magc_o        = s5_mag_q;
  assign magd_o        = s5_magd_q;

endmodule
`default_nettype wire

@@ rtl/pfp_norm_stage.sv @@
// One normalize step: shift the sum of squares left by a fixed even amount when its top is clear.
`default_nettype none
module pfp_norm_stage import pfp_pkg::*; #(
  parameter int QS     = 1,
  parameter int SIDE_W = 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire pfp_ctl_t          ctl_i,
  input  wire logic [SQ_W-1:0]   sq_i,
  input  wire logic [K_W-1:0]    k_i,
  input  wire logic [SIDE_W-1:0] side_i,
  output pfp_ctl_t               ctl_o,
  output logic [SQ_W-1:0]        sq_o,
  output logic [K_W-1:0]         k_o,
  output logic [SIDE_W-1:0]      side_o
);

  localparam int SHW = 2 * QS;

  pfp_ctl_t          ctl_q;
  logic [SQ_W-1:0]   sq_q;
  logic [K_W-1:0]    k_q;
  logic [SIDE_W-1:0] side_q;
  logic              hit;

  // top SHW bits all zero: shifting keeps the value in range
  assign hit = (sq_i[SQ_W-1 -: SHW] == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q   <= hit ? (sq_i << SHW) : sq_i;
    k_q    <= hit ? (k_i + K_W'(QS)) : k_i;
    side_q <= side_i;
  end

  assign ctl_o  = ctl_q;
  assign sq_o   = sq_q;
  assign k_o    = k_q;
  assign side_o = side_q;

endmodule
`default_nettype wire

@@ rtl/pfp_sqrt_cell.sv @@
// One bit of the integer square root; hands remainder, partial root and side data on.
`default_nettype none
module pfp_sqrt_cell import pfp_pkg::*; #(
  parameter int STEP   = 0,
  parameter int SIDE_W = 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire pfp_ctl_t          ctl_i,
  input  wire logic [SQ_W-1:0]   x_i,
  input  wire logic [SQ_W-1:0]   res_i,
  input  wire logic [SIDE_W-1:0] side_i,
  output pfp_ctl_t               ctl_o,
  output logic [SQ_W-1:0]        x_o,
  output logic [SQ_W-1:0]        res_o,
  output logic [SIDE_W-1:0]      side_o
);

  localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * STEP);

  pfp_ctl_t          ctl_q;
  logic [SQ_W-1:0]   x_q, x_d;
  logic [SQ_W-1:0]   res_q, res_d;
  logic [SIDE_W-1:0] side_q;
  logic [SQ_W-1:0]   trial;

  // trial subtract of res + bit
  always_comb begin
    trial = res_i + BIT;
    if (x_i >= trial) begin
      x_d   = x_i - trial;
      res_d = (res_i >> 1) + BIT;
    end else begin
      x_d   = x_i;
      res_d = res_i >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    res_q  <= res_d;
    side_q <= side_i;
  end

  assign ctl_o  = ctl_q;
  assign x_o    = x_q;
  assign res_o  = res_q;
  assign side_o = side_q;

endmodule
`default_nettype wire

@@ rtl/pfp_div_cell.sv @@
// One quotient bit of restoring division for all four lanes against the shared root.
`default_nettype none
module pfp_div_cell import pfp_pkg::*; #(
  parameter int QW = 2
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire pfp_ctl_t                     ctl_i,
  input  wire logic [ROOT_W-1:0]            root_i,
  input  wire logic [LANES-1:0][ROOT_W-1:0] rem_i,
  input  wire logic [LANES-1:0][QW-1:0]     dq_i,
  output pfp_ctl_t                          ctl_o,
  output logic [ROOT_W-1:0]                 root_o,
  output logic [LANES-1:0][ROOT_W-1:0]      rem_o,
  output logic [LANES-1:0][QW-1:0]          dq_o
);

  pfp_ctl_t                   ctl_q;
  logic [ROOT_W-1:0]          root_q;
  logic [LANES-1:0][ROOT_W-1:0] rem_q, rem_d;
  logic [LANES-1:0][QW-1:0]   dq_q, dq_d;
  logic [LANES-1:0][ROOT_W:0] sh, diff;
  logic [LANES-1:0]           ge;

  // shift in next dividend bit, compare, subtract; quotient bit enters at the bottom
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      sh[l]    = {rem_i[l], dq_i[l][QW-1]};
      diff[l]  = sh[l] - {1'b0, root_i};
      ge[l]    = (sh[l] >= {1'b0, root_i});
      rem_d[l] = ge[l] ? diff[l][ROOT_W-1:0] : sh[l][ROOT_W-1:0];
      dq_d[l]  = {dq_i[l][QW-2:0], ge[l]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    root_q <= root_i;
    rem_q  <= rem_d;
    dq_q   <= dq_d;
  end

  assign ctl_o  = ctl_q;
  assign root_o = root_q;
  assign rem_o  = rem_q;
  assign dq_o   = dq_q;

endmodule
`default_nettype wire

@@ rtl/plane_from_three_points.sv @@
// Requests pass the front, normalize, root, setup and division stages; then done_o pulses.
// Throughput: one request per cycle; busy is always low, as nothing in the chain waits.
// The depth is set mostly by the 32 square-root cells and one division cell per quotient bit.
// Each result is shown for one cycle on done_o; the receiver cannot stall it.
// Reset (rst_ni low, async) clears all valid bits; requests in flight are dropped.
// Top level: plane through three points with unit normal and offset.
`default_nettype none
module plane_from_three_points import pfp_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [COORD_BITS-1:0]        first_x_i,
  input  wire logic [COORD_BITS-1:0]        first_y_i,
  input  wire logic [COORD_BITS-1:0]        first_z_i,
  input  wire logic [COORD_BITS-1:0]        second_x_i,
  input  wire logic [COORD_BITS-1:0]        second_y_i,
  input  wire logic [COORD_BITS-1:0]        second_z_i,
  input  wire logic [COORD_BITS-1:0]        third_x_i,
  input  wire logic [COORD_BITS-1:0]        third_y_i,
  input  wire logic [COORD_BITS-1:0]        third_z_i,
  output logic                              done_o,
  output logic signed [NORM_W-1:0]          normal_x_o,
  output logic signed [NORM_W-1:0]          normal_y_o,
  output logic signed [NORM_W-1:0]          normal_z_o,
  output logic signed [OFF_W-1:0]           offset_o,
  output logic                              collinear_o
);

  localparam int CMW     = 2 * COORD_BITS + 1;
  localparam int MDW     = 3 * COORD_BITS + 2;
  localparam int NW      = COORD_BITS + ROOT_W + 1;       // shifted numerator
  localparam int QW      = COORD_BITS + FRAC_BITS + 2;    // quotient, one extra bit for rounding
  localparam int SIDE_W  = 3 * CMW + MDW;
  localparam int SIDE2_W = K_W + SIDE_W;
  localparam int NSTG    = 5;
  localparam int LAT     = COORD_BITS + FRAC_BITS + 46;
  localparam longint NORM_HI  = ((64'd1 << FRAC_BITS) - 64'd1 > NORM_MAX) ?
                                NORM_MAX : (64'd1 << FRAC_BITS) - 64'd1;
  localparam longint NORM_LOM = ((64'd1 << FRAC_BITS) > NORM_MIN_MAG) ?
                                NORM_MIN_MAG : (64'd1 << FRAC_BITS);

  logic req;
  assign busy = 1'b0;
  assign req  = start && !busy;

  // ---------------- front: cross product and sums
  pfp_ctl_t                  f_ctl;
  logic [SQ_W-1:0]           f_sq;
  logic [2:0][CMW-1:0]       f_magc;
  logic [MDW-1:0]            f_magd;

  pfp_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .pa_i   ({first_z_i, first_y_i, first_x_i}),
    .pb_i   ({second_z_i, second_y_i, second_x_i}),
    .pc_i   ({third_z_i, third_y_i, third_x_i}),
    .ctl_o  (f_ctl),
    .sq_o   (f_sq),
    .magc_o (f_magc),
    .magd_o (f_magd)
  );

  // ---------------- normalize chain: shifts of 32, 16, 8, 4, 2 bits
  pfp_ctl_t          nc_ctl  [NSTG+1];
  logic [SQ_W-1:0]   nc_sq   [NSTG+1];
  logic [K_W-1:0]    nc_k    [NSTG+1];
  logic [SIDE_W-1:0] nc_side [NSTG+1];

  assign nc_ctl[0]  = f_ctl;
  assign nc_sq[0]   = f_sq;
  assign nc_k[0]    = '0;
  assign nc_side[0] = {f_magc, f_magd};

  for (genvar j = 0; j < NSTG; j++) begin : g_norm
    pfp_norm_stage #(.QS(16 >> j), .SIDE_W(SIDE_W)) u_norm (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (nc_ctl[j]),
      .sq_i   (nc_sq[j]),
      .k_i    (nc_k[j]),
      .side_i (nc_side[j]),
      .ctl_o  (nc_ctl[j+1]),
      .sq_o   (nc_sq[j+1]),
      .k_o    (nc_k[j+1]),
      .side_o (nc_side[j+1])
    );
  end

  // ---------------- square root chain
  pfp_ctl_t           sc_ctl  [ROOT_STEPS+1];
  logic [SQ_W-1:0]    sc_x    [ROOT_STEPS+1];
  logic [SQ_W-1:0]    sc_res  [ROOT_STEPS+1];
  logic [SIDE2_W-1:0] sc_side [ROOT_STEPS+1];

  assign sc_ctl[0]  = nc_ctl[NSTG];
  assign sc_x[0]    = nc_sq[NSTG];
  assign sc_res[0]  = '0;
  assign sc_side[0] = {nc_k[NSTG], nc_side[NSTG]};

  for (genvar j = 0; j < ROOT_STEPS; j++) begin : g_sqrt
    pfp_sqrt_cell #(.STEP(j), .SIDE_W(SIDE2_W)) u_sqrt (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (sc_ctl[j]),
      .x_i    (sc_x[j]),
      .res_i  (sc_res[j]),
      .side_i (sc_side[j]),
      .ctl_o  (sc_ctl[j+1]),
      .x_o    (sc_x[j+1]),
      .res_o  (sc_res[j+1]),
      .side_o (sc_side[j+1])
    );
  end

  // ---------------- numerator setup: magnitude << k, split into remainder and dividend bits
  logic [K_W-1:0]               sr_k;
  logic [LANES-1:0][MDW-1:0]    sr_mag;
  logic [LANES-1:0][NW-1:0]     num;
  logic [LANES-1:0][ROOT_W-1:0] rem_init;
  logic [LANES-1:0][QW-1:0]     dq_init;

  assign sr_k = sc_side[ROOT_STEPS][SIDE2_W-1 -: K_W];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      if (l == OFF_LANE) begin
        sr_mag[l] = sc_side[ROOT_STEPS][MDW-1:0];
      end else begin
        sr_mag[l] = MDW'(sc_side[ROOT_STEPS][MDW + l*CMW +: CMW]);
      end
      num[l]      = NW'(sr_mag[l]) << sr_k;
      rem_init[l] = num[l][NW-1:COORD_BITS+1];
      dq_init[l]  = {num[l][COORD_BITS:0], {(FRAC_BITS+1){1'b0}}};
    end
  end

  pfp_ctl_t                     i_ctl_q;
  logic [ROOT_W-1:0]            i_root_q;
  logic [LANES-1:0][ROOT_W-1:0] i_rem_q;
  logic [LANES-1:0][QW-1:0]     i_dq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_ctl_q <= '0;
    end else begin
      i_ctl_q <= sc_ctl[ROOT_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    i_root_q <= sc_res[ROOT_STEPS][ROOT_W-1:0];
    i_rem_q  <= rem_init;
    i_dq_q   <= dq_init;
  end

  // ---------------- division chain
  pfp_ctl_t                     dc_ctl  [QW+1];
  logic [ROOT_W-1:0]            dc_root [QW+1];
  logic [LANES-1:0][ROOT_W-1:0] dc_rem  [QW+1];
  logic [LANES-1:0][QW-1:0]     dc_dq   [QW+1];

  assign dc_ctl[0]  = i_ctl_q;
  assign dc_root[0] = i_root_q;
  assign dc_rem[0]  = i_rem_q;
  assign dc_dq[0]   = i_dq_q;

  for (genvar j = 0; j < QW; j++) begin : g_div
    pfp_div_cell #(.QW(QW)) u_div (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (dc_ctl[j]),
      .root_i (dc_root[j]),
      .rem_i  (dc_rem[j]),
      .dq_i   (dc_dq[j]),
      .ctl_o  (dc_ctl[j+1]),
      .root_o (dc_root[j+1]),
      .rem_o  (dc_rem[j+1]),
      .dq_o   (dc_dq[j+1])
    );
  end

  // ---------------- rounding, sign, clamp, collinear override
  pfp_ctl_t                 o_ctl;
  logic [LANES-1:0][QW:0]   qr;
  logic [LANES-1:0][QW-1:0] qm;
  logic [LANES-1:0][63:0]   sv;

  assign o_ctl = dc_ctl[QW];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      qr[l] = {1'b0, dc_dq[QW][l]} + (QW+1)'(1);
      qm[l] = qr[l][QW:1];
      if (l == OFF_LANE) begin
        sv[l] = sat_apply(64'(qm[l]), o_ctl.dot_pos, OFF_MAX, OFF_MIN_MAG);
      end else begin
        sv[l] = sat_apply(64'(qm[l]), o_ctl.neg_c[l], NORM_HI, NORM_LOM);
      end
    end
  end

  logic                     done_q;
  logic signed [NORM_W-1:0] nx_q, ny_q, nz_q;
  logic signed [OFF_W-1:0]  off_q;
  logic                     col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= o_ctl.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    col_q <= o_ctl.zero;
    nx_q  <= o_ctl.zero ? '0 : NORM_W'(sv[0]);
    ny_q  <= o_ctl.zero ? '0 : NORM_W'(sv[1]);
    nz_q  <= o_ctl.zero ? '0 : NORM_W'(sv[2]);
    off_q <= o_ctl.zero ? '0 : OFF_W'(sv[OFF_LANE]);
  end

  assign done_o      = done_q;
  assign normal_x_o  = nx_q;
  assign normal_y_o  = ny_q;
  assign normal_z_o  = nz_q;
  assign offset_o    = off_q;
  assign collinear_o = col_q;

  // ---------------- checks
  a_lat_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req |-> ##LAT done_o) else $error("request did not complete at fixed latency");

  a_lat_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(req, LAT)) else $error("result without matching request");

  a_col_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && collinear_o |-> normal_x_o == '0 && normal_y_o == '0 &&
                              normal_z_o == '0 && offset_o == '0)
    else $error("collinear result not zeroed");

  a_unit_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !collinear_o |-> (normal_x_o != '0) || (normal_y_o != '0) ||
                               (normal_z_o != '0))
    else $error("unit normal came out zero");

endmodule
`default_nettype wire
